// File: rtl/c_source_reindenter_unit_assert.svh
// Assertion macros for the C source re-indenter.
// Used by the top level; expands to nothing when SYNTH is defined.
`ifndef C_SOURCE_REINDENTER_UNIT_ASSERT_SVH
`define C_SOURCE_REINDENTER_UNIT_ASSERT_SVH
`ifndef SYNTH
`define CSRU_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define CSRU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define CSRU_ASSERT(label, clk, rst_n, prop, msg)
`define CSRU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// File: rtl/csru_pkg.sv
// Shared types and constants of the C source re-indenter.
// No dependencies; used by csru_lex and c_source_reindenter_unit.
`timescale 1ns / 1ps
`default_nettype none

package csru_pkg;

	localparam int MAX_INDENT = 15;
	localparam int IND_W      = $clog2(MAX_INDENT + 1);
	localparam int CNT_W      = (IND_W > 3) ? IND_W : 3;

	localparam logic [7:0] CH_HASH   = 8'h23;
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_SPACE  = 8'h20;

	typedef enum logic [2:0] {
		MODE_LINE      = 3'd0,
		MODE_DIRECTIVE = 3'd1,
		MODE_NORMAL    = 3'd2,
		MODE_CMT_OPEN  = 3'd3,
		MODE_CMT_BODY  = 3'd4,
		MODE_CMT_TAIL  = 3'd5,
		MODE_STRING    = 3'd6
	} mode_t;

	// One run: up to four leading characters, a run of tabs, up to two trailing ones.
	typedef struct packed {
		logic [3:0][7:0]  pre;
		logic [2:0]       npre;
		logic [IND_W-1:0] ntab;
		logic [1:0][7:0]  post;
		logic [1:0]       npost;
		logic             brace_open;
		logic             brace_close;
	} plan_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EMPTY,
		ST_PRE,
		ST_TAB,
		ST_POST
	} seq_t;

endpackage

`default_nettype wire

// File: rtl/c_source_reindenter_unit.sv
// An accepted character loads the run registers; its output leaves via the output register.
// Each item, N output transactions (1..21), is emitted fully before the next; the single emit
//   sequencer with its shared down-counter hands out one character per cycle unless stalled.
// s_tready is high only while the sequencer is idle; output back-pressure stretches a run.
// Reset (arst_n low, asynchronous): line start mode, indent 0, brace counters 0, no output.
`timescale 1ns / 1ps
`default_nettype none
`include "c_source_reindenter_unit_assert.svh"

module c_source_reindenter_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] in_char
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [15:0]      m_tdata,   // [7:0] out_char, [8] brace_mismatch,
	                                    // [9] comment_open, [15:10] zero
	output logic             m_tlast,   // last_in_run
	output logic             m_tuser    // char_valid
);

	localparam logic [31:0] CNT_MAX = '1;

	// Lexer and brace state, updated at the transaction that takes a character in.
	csru_pkg::mode_t            mode_q;
	logic [csru_pkg::IND_W-1:0] indent_q;
	logic [31:0]                open_cnt_q;
	logic [31:0]                close_cnt_q;

	// Run being emitted.
	csru_pkg::seq_t             state_q, state_d;
	logic [3:0][7:0]            pre_q;
	logic [1:0][7:0]            post_q;
	logic [csru_pkg::IND_W-1:0] ntab_q;
	logic [1:0]                 npost_q;
	logic [csru_pkg::CNT_W-1:0] cnt_q;

	// Output register.
	logic                       m_valid_q;
	logic [7:0]                 m_char_q;
	logic                       m_cv_q;
	logic                       m_last_q;
	logic                       m_mis_q;
	logic                       m_cmt_q;

	csru_pkg::plan_t            plan;
	csru_pkg::mode_t            next_mode;

	logic                       acc;
	logic                       emit;
	logic                       phase_end;
	logic                       has_tab;
	logic                       has_post;
	logic [csru_pkg::CNT_W-1:0] cnt_dec;
	logic [csru_pkg::CNT_W-1:0] cnt_nxt;
	logic [csru_pkg::CNT_W-1:0] cnt_first;
	logic [7:0]                 emit_char;
	logic                       emit_cv;
	logic                       emit_last;
	logic                       mismatch;
	logic                       cmt_open;

	csru_lex u_lex (
		.mode      (mode_q),
		.indent    (indent_q),
		.in_char   (s_tdata),
		.plan      (plan),
		.next_mode (next_mode)
	);

	assign s_tready = (state_q == csru_pkg::ST_IDLE);
	assign acc      = s_tvalid && s_tready;
	assign emit     = (state_q != csru_pkg::ST_IDLE) && (!m_valid_q || m_tready);

	assign has_tab   = (ntab_q != '0);
	assign has_post  = (npost_q != 2'd0);
	assign cnt_dec   = cnt_q - 1'b1;
	assign phase_end = (cnt_q == csru_pkg::CNT_W'(1));

	// Flags reflect the state after the current character was taken in.
	assign mismatch = (open_cnt_q != close_cnt_q);
	assign cmt_open = (mode_q == csru_pkg::MODE_CMT_OPEN) ||
		(mode_q == csru_pkg::MODE_CMT_BODY) || (mode_q == csru_pkg::MODE_CMT_TAIL);

	// First nonempty phase of a new run and its length.
	always_comb begin
		if (plan.npre != 3'd0) begin
			cnt_first = csru_pkg::CNT_W'(plan.npre);
		end else if (plan.ntab != '0) begin
			cnt_first = csru_pkg::CNT_W'(plan.ntab);
		end else if (plan.npost != 2'd0) begin
			cnt_first = csru_pkg::CNT_W'(plan.npost);
		end else begin
			cnt_first = csru_pkg::CNT_W'(1);
		end
	end

	// Next state of the emit sequencer.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			csru_pkg::ST_IDLE: begin
				if (acc) begin
					if (plan.npre != 3'd0) begin
						state_d = csru_pkg::ST_PRE;
					end else if (plan.ntab != '0) begin
						state_d = csru_pkg::ST_TAB;
					end else if (plan.npost != 2'd0) begin
						state_d = csru_pkg::ST_POST;
					end else begin
						state_d = csru_pkg::ST_EMPTY;
					end
				end
			end
			csru_pkg::ST_EMPTY: begin
				if (emit) begin
					state_d = csru_pkg::ST_IDLE;
				end
			end
			csru_pkg::ST_PRE: begin
				if (emit && phase_end) begin
					if (has_tab) begin
						state_d = csru_pkg::ST_TAB;
					end else if (has_post) begin
						state_d = csru_pkg::ST_POST;
					end else begin
						state_d = csru_pkg::ST_IDLE;
					end
				end
			end
			csru_pkg::ST_TAB: begin
				if (emit && phase_end) begin
					state_d = has_post ? csru_pkg::ST_POST : csru_pkg::ST_IDLE;
				end
			end
			csru_pkg::ST_POST: begin
				if (emit && phase_end) begin
					state_d = csru_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = csru_pkg::ST_IDLE;
			end
		endcase
	end

	// Sequencer outputs: the character of this cycle and the counter reload.
	always_comb begin
		emit_char = 8'h00;
		emit_cv   = 1'b1;
		emit_last = 1'b0;
		cnt_nxt   = cnt_dec;
		unique case (state_q)
			csru_pkg::ST_EMPTY: begin
				emit_cv   = 1'b0;
				emit_last = 1'b1;
			end
			csru_pkg::ST_PRE: begin
				emit_char = pre_q[0];
				if (phase_end) begin
					if (has_tab) begin
						cnt_nxt = csru_pkg::CNT_W'(ntab_q);
					end else if (has_post) begin
						cnt_nxt = csru_pkg::CNT_W'(npost_q);
					end else begin
						emit_last = 1'b1;
					end
				end
			end
			csru_pkg::ST_TAB: begin
				emit_char = csru_pkg::CH_TAB;
				if (phase_end) begin
					if (has_post) begin
						cnt_nxt = csru_pkg::CNT_W'(npost_q);
					end else begin
						emit_last = 1'b1;
					end
				end
			end
			csru_pkg::ST_POST: begin
				emit_char = post_q[0];
				emit_last = phase_end;
			end
			default: begin
				emit_cv = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= csru_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Lexer state and saturating brace bookkeeping.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= csru_pkg::MODE_LINE;
			indent_q    <= '0;
			open_cnt_q  <= '0;
			close_cnt_q <= '0;
		end else if (acc) begin
			mode_q <= next_mode;
			if (plan.brace_open) begin
				if (open_cnt_q != CNT_MAX) begin
					open_cnt_q <= open_cnt_q + 32'd1;
				end
				if (indent_q < csru_pkg::IND_W'(csru_pkg::MAX_INDENT)) begin
					indent_q <= indent_q + 1'b1;
				end
			end
			if (plan.brace_close) begin
				if (close_cnt_q != CNT_MAX) begin
					close_cnt_q <= close_cnt_q + 32'd1;
				end
				if (indent_q != '0) begin
					indent_q <= indent_q - 1'b1;
				end
			end
		end
	end

	// Run payload: load on a new character, shift out as characters leave.
	always_ff @(posedge clk) begin
		if (acc) begin
			pre_q   <= plan.pre;
			post_q  <= plan.post;
			ntab_q  <= plan.ntab;
			npost_q <= plan.npost;
			cnt_q   <= cnt_first;
		end else if (emit) begin
			cnt_q <= cnt_nxt;
			if (state_q == csru_pkg::ST_PRE) begin
				pre_q <= {8'h00, pre_q[3:1]};
			end
			if (state_q == csru_pkg::ST_POST) begin
				post_q <= {8'h00, post_q[1]};
			end
		end
	end

	// Output register: hold while the sink stalls, drop valid once taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (emit) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			m_char_q <= emit_char;
			m_cv_q   <= emit_cv;
			m_last_q <= emit_last;
			m_mis_q  <= mismatch;
			m_cmt_q  <= cmt_open;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {6'b0, m_cmt_q, m_mis_q, m_char_q};
	assign m_tlast  = m_last_q;
	assign m_tuser  = m_cv_q;

	// Every accepted character starts a run, so the input closes the next cycle.
	`CSRU_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, acc, !s_tready,
		"input still ready after a character was accepted")
	// An empty run is always a single, final transaction.
	`CSRU_ASSERT(a_empty_is_last, clk, arst_n, !m_tvalid || m_tuser || m_tlast,
		"empty output transaction without last flag")
	// Indent depth stays within its bound.
	`CSRU_ASSERT(a_indent_bound, clk, arst_n,
		indent_q <= csru_pkg::IND_W'(csru_pkg::MAX_INDENT), "indent depth beyond maximum")
	// Brace counters only move at an input transaction.
	`CSRU_ASSERT_NEXT(a_cnt_hold, clk, arst_n, !acc,
		$stable(open_cnt_q) && $stable(close_cnt_q), "brace counter moved without input")

endmodule

`default_nettype wire

// File: rtl/csru_lex.sv
// Lexer decode: maps mode, indent depth and one character to a run plan and next mode.
// Depends on csru_pkg.
`timescale 1ns / 1ps
`default_nettype none

module csru_lex (
	input  wire csru_pkg::mode_t        mode,
	input  wire logic [csru_pkg::IND_W-1:0] indent,
	input  wire logic [7:0]             in_char,
	output csru_pkg::plan_t             plan,
	output csru_pkg::mode_t             next_mode
);

	logic [csru_pkg::IND_W-1:0] tab_close;
	logic                       is_quote;
	logic                       is_blank;

	assign tab_close = (indent == '0) ? '0 : indent - 1'b1;
	assign is_quote  = (in_char == csru_pkg::CH_SQUOTE) || (in_char == csru_pkg::CH_DQUOTE);
	assign is_blank  = (in_char == csru_pkg::CH_SPACE) || (in_char == csru_pkg::CH_TAB) ||
		(in_char == csru_pkg::CH_NL) || (in_char == csru_pkg::CH_CR);

	always_comb begin
		plan      = '0;
		next_mode = mode;
		unique case (mode)
			csru_pkg::MODE_DIRECTIVE: begin
				plan.pre[0] = in_char;
				plan.npre   = 3'd1;
				if (in_char == csru_pkg::CH_NL) begin
					next_mode = csru_pkg::MODE_LINE;
				end
			end
			csru_pkg::MODE_NORMAL: begin
				if (in_char == csru_pkg::CH_LBRACE) begin
					plan.pre[0]     = csru_pkg::CH_NL;
					plan.npre       = 3'd1;
					plan.ntab       = indent;
					plan.post[0]    = csru_pkg::CH_LBRACE;
					plan.post[1]    = csru_pkg::CH_NL;
					plan.npost      = 2'd2;
					plan.brace_open = 1'b1;
					next_mode       = csru_pkg::MODE_LINE;
				end else if (in_char == csru_pkg::CH_RBRACE) begin
					plan.pre[0]      = csru_pkg::CH_NL;
					plan.npre        = 3'd1;
					plan.ntab        = tab_close;
					plan.post[0]     = csru_pkg::CH_RBRACE;
					plan.post[1]     = csru_pkg::CH_NL;
					plan.npost       = 2'd2;
					plan.brace_close = 1'b1;
					next_mode        = csru_pkg::MODE_LINE;
				end else if (is_quote) begin
					plan.pre[0] = in_char;
					plan.npre   = 3'd1;
					next_mode   = csru_pkg::MODE_STRING;
				end else if (in_char == csru_pkg::CH_SLASH) begin
					plan.pre[0]  = csru_pkg::CH_NL;
					plan.npre    = 3'd1;
					plan.ntab    = indent;
					plan.post[0] = in_char;
					plan.npost   = 2'd1;
					next_mode    = csru_pkg::MODE_CMT_OPEN;
				end else if (in_char == csru_pkg::CH_NL) begin
					plan.pre[0] = csru_pkg::CH_NL;
					plan.npre   = 3'd1;
					next_mode   = csru_pkg::MODE_LINE;
				end else begin
					plan.pre[0] = in_char;
					plan.npre   = 3'd1;
				end
			end
			csru_pkg::MODE_CMT_OPEN: begin
				plan.pre[0] = in_char;
				plan.npre   = 3'd1;
				next_mode   = (in_char == csru_pkg::CH_STAR) ? csru_pkg::MODE_CMT_BODY :
					csru_pkg::MODE_NORMAL;
			end
			csru_pkg::MODE_CMT_BODY: begin
				// skip blanks until the comment text starts
				if (!is_blank) begin
					plan.pre[0] = csru_pkg::CH_SPACE;
					plan.pre[1] = in_char;
					plan.npre   = 3'd2;
					next_mode   = csru_pkg::MODE_CMT_TAIL;
				end
			end
			csru_pkg::MODE_CMT_TAIL: begin
				if ((in_char == csru_pkg::CH_NL) || (in_char == csru_pkg::CH_CR)) begin
					// close the comment here and reopen it on the next line
					plan.pre[0]  = csru_pkg::CH_SPACE;
					plan.pre[1]  = csru_pkg::CH_STAR;
					plan.pre[2]  = csru_pkg::CH_SLASH;
					plan.pre[3]  = csru_pkg::CH_NL;
					plan.npre    = 3'd4;
					plan.ntab    = indent;
					plan.post[0] = csru_pkg::CH_SLASH;
					plan.post[1] = csru_pkg::CH_STAR;
					plan.npost   = 2'd2;
					next_mode    = csru_pkg::MODE_CMT_BODY;
				end else if (in_char == csru_pkg::CH_SLASH) begin
					plan.pre[0] = in_char;
					plan.pre[1] = csru_pkg::CH_NL;
					plan.npre   = 3'd2;
					next_mode   = csru_pkg::MODE_LINE;
				end else begin
					plan.pre[0] = in_char;
					plan.npre   = 3'd1;
				end
			end
			csru_pkg::MODE_STRING: begin
				plan.pre[0] = in_char;
				plan.npre   = 3'd1;
				if (is_quote) begin
					next_mode = csru_pkg::MODE_NORMAL;
				end
			end
			default: begin
				// line start; an unused code behaves the same
				next_mode = csru_pkg::MODE_LINE;
				if ((in_char == csru_pkg::CH_SPACE) || (in_char == csru_pkg::CH_TAB) ||
					(in_char == csru_pkg::CH_NL)) begin
					plan = '0;
				end else if (in_char == csru_pkg::CH_HASH) begin
					plan.pre[0] = in_char;
					plan.npre   = 3'd1;
					next_mode   = csru_pkg::MODE_DIRECTIVE;
				end else if (in_char == csru_pkg::CH_LBRACE) begin
					plan.ntab       = indent;
					plan.post[0]    = csru_pkg::CH_LBRACE;
					plan.post[1]    = csru_pkg::CH_NL;
					plan.npost      = 2'd2;
					plan.brace_open = 1'b1;
				end else if (in_char == csru_pkg::CH_RBRACE) begin
					plan.ntab        = tab_close;
					plan.post[0]     = csru_pkg::CH_RBRACE;
					plan.post[1]     = csru_pkg::CH_NL;
					plan.npost       = 2'd2;
					plan.brace_close = 1'b1;
				end else if (in_char == csru_pkg::CH_SLASH) begin
					plan.ntab    = indent;
					plan.post[0] = in_char;
					plan.npost   = 2'd1;
					next_mode    = csru_pkg::MODE_CMT_OPEN;
				end else begin
					plan.ntab    = indent;
					plan.post[0] = in_char;
					plan.npost   = 2'd1;
					next_mode    = csru_pkg::MODE_NORMAL;
				end
			end
		endcase
	end

endmodule

`default_nettype wire
